@@ rtl/kmsa_pkg.sv @@
package kmsa_pkg;

	localparam int SLOT_COUNT = 512;
	localparam int PAGE_BITS  = 20;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_NEW  = CNT_W'(2);
	localparam logic [CNT_W-1:0] COUNT_IDLE = CNT_W'(1);

	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_UNMAP = 2'd1;
	localparam logic [1:0] OP_PIN   = 2'd2;

	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_NOT_MAPPED = 2'd1;
	localparam logic [1:0] STS_NO_SLOT    = 2'd2;
	localparam logic [1:0] STS_COUNT_ERR  = 2'd3;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_LOOKUP = 3'd2;
	localparam logic [2:0] S_ADV    = 3'd3;
	localparam logic [2:0] S_CHK_RD = 3'd4;
	localparam logic [2:0] S_CHK_EV = 3'd5;
	localparam logic [2:0] S_SWEEP  = 3'd6;

	typedef struct packed {
		logic [CNT_W-1:0]     cnt;
		logic [PAGE_BITS-1:0] tag;
	} entry_t;

endpackage

@@ rtl/kernel_map_slot_allocator.sv @@
// Reference-counted slot allocator for high pages.
// Input channel (in_valid/in_ready): op and page_number. Output channel
// (out_valid/out_ready): slot, status and flush_requested, one item per input.
// All slot state sits in one memory of SLOT_COUNT entries (count and tag),
// read through a registered output; the sequencer reads, modifies and writes back.
// A lookup reads the entries in order from slot 0 until the first live
// entry with a matching tag, or through the last slot on a miss. A map that
// misses then steps the round-robin pointer, with the states S_ADV, S_CHK_RD
// and S_CHK_EV for each slot checked; a wrap to slot 0 adds a sweep over
// every entry. An unused op is answered straight from idle, with no lookup.
// One item is in flight at a time; in_ready is low from acceptance until
// the result has been taken, so a stalled receiver holds the block.
// Reset: a clearing pass over all SLOT_COUNT entries zeroes every count and
// every tag; no input item is accepted during it.
module kernel_map_slot_allocator
	import kmsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SLOT_W-1:0]    slot,
	output logic [1:0]           status,
	output logic                 flush_requested
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [SLOT_W:0]   FULL      = (SLOT_W+1)'(SLOT_COUNT);

	entry_t mem [SLOT_COUNT];
	entry_t rdata_q;

	logic [2:0]           state_q;
	logic [1:0]           op_q;
	logic [PAGE_BITS-1:0] pg_q;
	logic [SLOT_W:0]      idx_q;
	logic                 v_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic [SLOT_W-1:0]    pos_q;
	logic [SLOT_W-1:0]    scan_q;
	logic [SLOT_W:0]      budget_q;
	logic                 flush_q;
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [1:0]           status_q;
	logic                 fl_out_q;

	logic                 hit;
	logic                 we;
	logic [SLOT_W-1:0]    wa;
	logic [SLOT_W-1:0]    ra;
	entry_t               wd;
	logic [SLOT_W-1:0]    pos_nxt;

	assign in_ready        = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid       = out_valid_q;
	assign slot            = slot_q;
	assign status          = status_q;
	assign flush_requested = fl_out_q;

	assign hit     = (rdata_q.cnt != '0) && (rdata_q.tag == pg_q);
	assign pos_nxt = (pos_q == LAST_SLOT) ? '0 : pos_q + 1'b1;

	always_comb begin
		we = 1'b0;
		wa = idx_s1;
		wd = rdata_q;
		ra = idx_q[SLOT_W-1:0];
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = idx_q[SLOT_W-1:0];
				wd = '0;
			end
			S_LOOKUP: begin
				if (v_s1 && hit) begin
					if (op_q == OP_UNMAP) begin
						if (rdata_q.cnt > COUNT_IDLE) begin
							we     = 1'b1;
							wd.cnt = rdata_q.cnt - 1'b1;
						end
					end else if (rdata_q.cnt != COUNT_MAX) begin
						we     = 1'b1;
						wd.cnt = rdata_q.cnt + 1'b1;
					end
				end
			end
			S_CHK_RD: ra = pos_q;
			S_CHK_EV: begin
				if (rdata_q.cnt == '0) begin
					we     = 1'b1;
					wa     = pos_q;
					wd.cnt = COUNT_NEW;
					wd.tag = pg_q;
				end
			end
			S_SWEEP: begin
				if (v_s1 && rdata_q.cnt == COUNT_IDLE) begin
					we     = 1'b1;
					wd.cnt = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			pg_q        <= '0;
			idx_s1      <= '0;
			pos_q       <= '0;
			budget_q    <= '0;
			flush_q     <= 1'b0;
			slot_q      <= '0;
			status_q    <= STS_OK;
			fl_out_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[SLOT_W-1:0] == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q  <= op;
						pg_q  <= page_number;
						idx_q <= '0;
						v_s1  <= 1'b0;
						if (op inside {OP_MAP, OP_UNMAP, OP_PIN}) begin
							state_q <= S_LOOKUP;
						end else begin
							slot_q      <= '0;
							status_q    <= STS_NOT_MAPPED;
							fl_out_q    <= 1'b0;
							out_valid_q <= 1'b1;
						end
					end
				end
				S_LOOKUP: begin
					v_s1   <= idx_q < FULL;
					idx_s1 <= idx_q[SLOT_W-1:0];
					if (idx_q < FULL) begin
						idx_q <= idx_q + 1'b1;
					end
					if (v_s1 && hit) begin
						fl_out_q    <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if ((op_q == OP_UNMAP && rdata_q.cnt <= COUNT_IDLE) ||
						    (op_q != OP_UNMAP && rdata_q.cnt == COUNT_MAX)) begin
							slot_q   <= '0;
							status_q <= STS_COUNT_ERR;
						end else begin
							slot_q   <= idx_s1;
							status_q <= STS_OK;
						end
					end else if (v_s1 && idx_s1 == LAST_SLOT) begin
						if (op_q == OP_MAP) begin
							pos_q    <= scan_q;
							budget_q <= FULL;
							flush_q  <= 1'b0;
							state_q  <= S_ADV;
						end else begin
							slot_q      <= '0;
							status_q    <= STS_NOT_MAPPED;
							fl_out_q    <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
				end
				S_ADV: begin
					pos_q <= pos_nxt;
					if (pos_nxt == '0) begin
						budget_q <= FULL;
						idx_q    <= '0;
						v_s1     <= 1'b0;
						state_q  <= S_SWEEP;
					end else begin
						state_q <= S_CHK_RD;
					end
				end
				S_CHK_RD: state_q <= S_CHK_EV;
				S_CHK_EV: begin
					if (rdata_q.cnt == '0) begin
						scan_q      <= pos_q;
						slot_q      <= pos_q;
						status_q    <= STS_OK;
						fl_out_q    <= flush_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (budget_q == (SLOT_W+1)'(1)) begin
						scan_q      <= pos_q;
						slot_q      <= '0;
						status_q    <= STS_NO_SLOT;
						fl_out_q    <= flush_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						budget_q <= budget_q - 1'b1;
						state_q  <= S_ADV;
					end
				end
				S_SWEEP: begin
					v_s1   <= idx_q < FULL;
					idx_s1 <= idx_q[SLOT_W-1:0];
					if (idx_q < FULL) begin
						idx_q <= idx_q + 1'b1;
					end
					if (v_s1 && rdata_q.cnt == COUNT_IDLE) begin
						flush_q <= 1'b1;
					end
					if (v_s1 && idx_s1 == LAST_SLOT) begin
						state_q <= S_CHK_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("ready while busy");

	a_err_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != STS_OK) |-> (slot_q == '0))
		else $error("nonzero slot on error");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE || out_valid_q))
		else $error("item dropped");

	a_flush_only_map: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fl_out_q) |-> (op_q == OP_MAP))
		else $error("flush on non-map");

endmodule
